[rtl/core/mwpo_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwpo_pkg
// Shared types, register indexes, waveform codes and defaults of the oscillator.
// ----------------------------------------------------------------------------
package mwpo_pkg;

  localparam int DEF_PHASE_BITS       = 24;
  localparam int DEF_MAX_HARMONICS    = 128;
  localparam int DEF_SINE_TABLE_DEPTH = 1024;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_WAVEFORM       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LEVEL          = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_HARMONIC_COUNT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_IMPULSE_GAIN   = 3'd4;

  // waveform codes
  localparam logic [3:0] WAVE_SILENT   = 4'd0;
  localparam logic [3:0] WAVE_SINE     = 4'd1;
  localparam logic [3:0] WAVE_IMPULSE  = 4'd2;
  localparam logic [3:0] WAVE_SQUARE   = 4'd3;
  localparam logic [3:0] WAVE_SAW      = 4'd4;
  localparam logic [3:0] WAVE_TRIANGLE = 4'd5;
  localparam logic [3:0] WAVE_BL_IMP   = 4'd6;
  localparam logic [3:0] WAVE_BL_SQR   = 4'd7;
  localparam logic [3:0] WAVE_BL_SAW   = 4'd8;
  localparam logic [3:0] WAVE_BL_TRI   = 4'd9;

  localparam int SAMPLE_W = 18;
  localparam int ACC_W    = 48;

  // Taylor coefficients of sin(pi/2 u), Q30, for the table build
  localparam longint unsigned TAYLOR_Q30 [7] = '{
    64'd1686629713, 64'd693598668, 64'd85569305, 64'd5026996,
    64'd172272, 64'd3864, 64'd61
  };

  typedef struct packed {
    logic [3:0]  waveform;
    logic [23:0] phase_step;
    logic [15:0] level;
    logic [7:0]  harmonic_count;
    logic [15:0] impulse_gain;
  } cfg_t;

endpackage

[rtl/core/mwpo_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwpo_front
// Accepts requests, applies restart, records phase and wrap flag, advances phase.
// ----------------------------------------------------------------------------
module mwpo_front
  import mwpo_pkg::*;
#(
  parameter int PHASE_BITS = DEF_PHASE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [23:0]           phase_step,
  input  logic                  push,
  input  logic                  phase_restart,
  input  logic                  q_full,
  output logic                  q_push,
  output logic [PHASE_BITS:0]   q_data
);

  logic [PHASE_BITS-1:0] phase_acc;
  logic                  wrapped_last;
  logic [PHASE_BITS-1:0] p_cur;
  logic                  w_cur;
  logic [PHASE_BITS+23:0] step_wide;
  logic [PHASE_BITS-1:0] step_al;
  logic [PHASE_BITS:0]   sum;

  // align the 0.24 step to the accumulator width
  assign step_wide = {phase_step, {PHASE_BITS{1'b0}}};
  assign step_al   = step_wide[PHASE_BITS+23:24];

  assign q_push = push && !q_full;
  assign p_cur  = phase_restart ? '0 : phase_acc;
  assign w_cur  = phase_restart ? 1'b0 : wrapped_last;
  assign q_data = {w_cur, p_cur};
  assign sum    = {1'b0, p_cur} + {1'b0, step_al};

  // advance phase on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc    <= '0;
      wrapped_last <= 1'b0;
    end else if (q_push) begin
      phase_acc    <= sum[PHASE_BITS-1:0];
      wrapped_last <= sum[PHASE_BITS];
    end
  end

endmodule

[rtl/core/mwpo_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwpo_queue
// Two-entry queue between the phase front end and the sample engine.
// ----------------------------------------------------------------------------
module mwpo_queue #(
  parameter int W = 25
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr,
  input  logic [W-1:0] wdata,
  input  logic         rd,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         empty
);

  logic [W-1:0] mem [2];
  logic         wptr;
  logic         rptr;
  logic [1:0]   count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rdata = mem[rptr];

  // store entries
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wdata;
    end
  end

  // track pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr) begin
        wptr <= ~wptr;
      end
      if (rd) begin
        rptr <= ~rptr;
      end
      case ({wr, rd})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/core/mwpo_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwpo_back
// Sample engine: forms one sample from a queued phase, walking harmonics.
// ----------------------------------------------------------------------------
module mwpo_back
  import mwpo_pkg::*;
#(
  parameter int PHASE_BITS       = DEF_PHASE_BITS,
  parameter int MAX_HARMONICS    = DEF_MAX_HARMONICS,
  parameter int SINE_TABLE_DEPTH = DEF_SINE_TABLE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  cfg_t                       cfg,
  input  logic                       q_empty,
  input  logic [PHASE_BITS:0]        q_data,
  output logic                       q_pop,
  output logic                       empty,
  input  logic                       pop,
  output logic signed [SAMPLE_W-1:0] sample,
  output logic                       clipped
);

  localparam int QB  = PHASE_BITS - 2;
  localparam int AW  = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int HW  = $clog2(MAX_HARMONICS + 1);
  localparam int CW  = (HW > 8) ? HW : 8;
  localparam int DVW = 2 * HW;
  localparam int PW  = 33;
  localparam logic [AW-1:0] DEPTH_C = AW'(SINE_TABLE_DEPTH);
  localparam logic signed [PHASE_BITS+3:0] FULL_S = (PHASE_BITS+4)'(1) <<< PHASE_BITS;

  typedef logic [16:0] rom_t [SINE_TABLE_DEPTH+1];

  // quarter-wave sine table, Q16, built at elaboration
  function automatic rom_t build_rom();
    rom_t r;
    longint unsigned u, u2, t, x, s;
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      u  = (longint'(i) << 30) / SINE_TABLE_DEPTH;
      u2 = (u * u) >> 30;
      t  = TAYLOR_Q30[6];
      for (int k = 5; k >= 0; k--) begin
        x = (u2 * t) >> 30;
        t = (x > TAYLOR_Q30[k]) ? 64'd0 : TAYLOR_Q30[k] - x;
      end
      s = (u * t) >> 30;
      s = (s + 64'd8192) >> 14;
      if (s > 64'd65536) begin
        s = 64'd65536;
      end
      r[i] = s[16:0];
    end
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  typedef enum logic [2:0] {
    S_IDLE, S_SIMPLE, S_IDX, S_ROM, S_MUL, S_DIV, S_ACC, S_FIN
  } state_t;

  state_t                      state;
  logic [3:0]                  mode;
  logic [PHASE_BITS-1:0]       p;
  logic                        wflag;
  logic [PHASE_BITS-1:0]       ph;
  logic [HW-1:0]               h;
  logic [HW-1:0]               nh;
  logic [15:0]                 weight;
  logic                        odd_only;
  logic [AW-1:0]               rom_addr;
  logic [16:0]                 rom_q;
  logic                        neg;
  logic [DVW-1:0]              divisor;
  logic [PW-1:0]               quo;
  logic [PW:0]                 rem;
  logic [5:0]                  div_cnt;
  logic signed [ACC_W-1:0]     acc;
  logic                        out_valid;

  // harmonic count clamp
  logic [CW-1:0] hc_ext;
  logic [HW-1:0] nh_clamp;
  assign hc_ext   = CW'(cfg.harmonic_count);
  assign nh_clamp = (hc_ext > CW'(MAX_HARMONICS)) ? HW'(MAX_HARMONICS) : HW'(hc_ext);

  // table index for the current harmonic phase
  logic [1:0]           quad;
  logic [QB+AW-1:0]     idx_prod;
  logic [AW-1:0]        idx_raw;
  assign quad     = ph[PHASE_BITS-1:PHASE_BITS-2];
  assign idx_prod = ph[QB-1:0] * DEPTH_C;
  assign idx_raw  = idx_prod[QB+AW-1 -: AW];

  // shapes that need no table
  logic signed [PHASE_BITS+3:0] four_p, two_p, sv, sv_abs;
  logic [PHASE_BITS:0]          sm_mag;
  logic [PHASE_BITS+16:0]       sm_prod;
  logic [PW-1:0]                sm_scaled;
  logic signed [ACC_W-1:0]      sm_acc;
  logic signed [ACC_W-1:0]      lvl16;
  assign four_p    = $signed({2'b00, p, 2'b00});
  assign two_p     = $signed({3'b000, p, 1'b0});
  assign sv_abs    = (sv < 0) ? -sv : sv;
  assign sm_mag    = sv_abs[PHASE_BITS:0];
  assign sm_prod   = sm_mag * cfg.level;
  assign sm_scaled = sm_prod[PHASE_BITS+16:PHASE_BITS-16];
  assign lvl16     = ACC_W'({cfg.level, 16'h0000});

  always_comb begin
    sv     = '0;
    sm_acc = '0;
    case (mode)
      WAVE_SAW: begin
        sv     = two_p - FULL_S;
        sm_acc = (sv < 0) ? -ACC_W'(sm_scaled) : ACC_W'(sm_scaled);
      end
      WAVE_TRIANGLE: begin
        sv     = p[PHASE_BITS-1] ? (FULL_S + FULL_S + FULL_S - four_p) : (four_p - FULL_S);
        sm_acc = (sv < 0) ? -ACC_W'(sm_scaled) : ACC_W'(sm_scaled);
      end
      WAVE_IMPULSE: begin
        sm_acc = wflag ? lvl16 : '0;
      end
      WAVE_SQUARE: begin
        sm_acc = p[PHASE_BITS-1] ? lvl16 : -lvl16;
      end
      default: begin
        sm_acc = '0;
      end
    endcase
  end

  // divider step
  logic [PW:0] rem_sh;
  logic        q_bit;
  assign rem_sh = {rem[PW-1:0], quo[PW-1]};
  assign q_bit  = (rem_sh >= (PW+1)'(divisor));

  // saturation of the finished sum
  logic [ACC_W-1:0] acc_mag;
  logic [31:0]      s_mag;
  logic             acc_neg;
  logic             clip_hi, clip_lo;
  assign acc_neg = acc[ACC_W-1];
  assign acc_mag = acc_neg ? -acc : acc;
  assign s_mag   = acc_mag[47:16];
  assign clip_hi = !acc_neg && (s_mag > 32'd131071);
  assign clip_lo = acc_neg && (s_mag > 32'd131072);

  assign empty = !out_valid;
  assign q_pop = (state == S_IDLE) && !q_empty;

  // registered table read
  always_ff @(posedge clk) begin
    rom_q <= SINE_ROM[rom_addr];
  end

  // sample sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (pop && out_valid && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            mode     <= cfg.waveform;
            p        <= q_data[PHASE_BITS-1:0];
            wflag    <= q_data[PHASE_BITS];
            ph       <= q_data[PHASE_BITS-1:0];
            h        <= HW'(1);
            acc      <= '0;
            odd_only <= (cfg.waveform == WAVE_BL_SQR) || (cfg.waveform == WAVE_BL_TRI);
            weight   <= (cfg.waveform == WAVE_BL_IMP) ? cfg.impulse_gain : cfg.level;
            if (cfg.waveform == WAVE_SINE) begin
              nh    <= HW'(1);
              state <= S_IDX;
            end else if (cfg.waveform == WAVE_BL_IMP || cfg.waveform == WAVE_BL_SQR ||
                         cfg.waveform == WAVE_BL_SAW || cfg.waveform == WAVE_BL_TRI) begin
              nh    <= nh_clamp;
              state <= (nh_clamp == '0) ? S_FIN : S_IDX;
            end else begin
              state <= S_SIMPLE;
            end
          end
        end
        S_SIMPLE: begin
          acc   <= sm_acc;
          state <= S_FIN;
        end
        S_IDX: begin
          if (odd_only && !h[0]) begin
            // skip even harmonic
            ph <= ph + p;
            h  <= h + HW'(1);
            state <= (h == nh) ? S_FIN : S_IDX;
          end else begin
            rom_addr <= quad[0] ? (DEPTH_C - idx_raw) : idx_raw;
            neg      <= quad[1];
            case (mode)
              WAVE_BL_SQR, WAVE_BL_SAW: divisor <= DVW'(h);
              WAVE_BL_TRI:              divisor <= DVW'(h) * DVW'(h);
              default:                  divisor <= DVW'(1);
            endcase
            state <= S_ROM;
          end
        end
        S_ROM: begin
          state <= S_MUL;
        end
        S_MUL: begin
          quo     <= rom_q * weight;
          rem     <= '0;
          div_cnt <= 6'(PW);
          state   <= (divisor == DVW'(1)) ? S_ACC : S_DIV;
        end
        S_DIV: begin
          rem     <= q_bit ? (rem_sh - (PW+1)'(divisor)) : rem_sh;
          quo     <= {quo[PW-2:0], q_bit};
          div_cnt <= div_cnt - 6'd1;
          if (div_cnt == 6'd1) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          acc   <= neg ? (acc - ACC_W'(quo)) : (acc + ACC_W'(quo));
          ph    <= ph + p;
          h     <= h + HW'(1);
          state <= (h == nh) ? S_FIN : S_IDX;
        end
        S_FIN: begin
          // hold until the output register is free
          if (!out_valid || pop) begin
            out_valid <= 1'b1;
            clipped   <= clip_hi || clip_lo;
            if (clip_hi) begin
              sample <= SAMPLE_W'(131071);
            end else if (clip_lo) begin
              sample <= -SAMPLE_W'(131072);
            end else begin
              sample <= acc_neg ? -s_mag[SAMPLE_W-1:0] : s_mag[SAMPLE_W-1:0];
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/core/multi_waveform_phase_oscillator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_waveform_phase_oscillator
// Phase-accumulator oscillator with table sine and band-limited harmonic modes.
// ----------------------------------------------------------------------------
// Each request yields one sample. The front end takes a request per cycle into
// a two-entry queue while it is not full; the sample engine then works one
// sample at a time. Silent, impulse, square, saw and triangle pass one simple
// step; sine passes the index, table read, multiply and accumulate states.
// The band-limited modes walk the harmonics in one shared datapath through
// those states per summed harmonic, plus the bit-serial divider for each term
// weighted by 1/h or 1/h^2 (every harmonic above the first in square, saw and
// triangle), and a single index step per skipped even harmonic. A result left
// unread holds the engine. The walk and the divider set the rate.
module multi_waveform_phase_oscillator
  import mwpo_pkg::*;
#(
  parameter int PHASE_BITS       = DEF_PHASE_BITS,
  parameter int MAX_HARMONICS    = DEF_MAX_HARMONICS,
  parameter int SINE_TABLE_DEPTH = DEF_SINE_TABLE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [CFG_INDEX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic                       push,
  output logic                       full,
  input  logic                       phase_restart,
  output logic                       empty,
  input  logic                       pop,
  output logic signed [SAMPLE_W-1:0] sample,
  output logic                       clipped
);

  cfg_t                cfg;
  logic                q_push;
  logic [PHASE_BITS:0] q_wdata;
  logic [PHASE_BITS:0] q_rdata;
  logic                q_pop;
  logic                q_empty;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WAVEFORM:       cfg.waveform       <= cfg_data[3:0];
        REG_PHASE_STEP:     cfg.phase_step     <= cfg_data[23:0];
        REG_LEVEL:          cfg.level          <= cfg_data[15:0];
        REG_HARMONIC_COUNT: cfg.harmonic_count <= cfg_data[7:0];
        REG_IMPULSE_GAIN:   cfg.impulse_gain   <= cfg_data[15:0];
        default:            cfg                <= cfg;
      endcase
    end
  end

  mwpo_front #(
    .PHASE_BITS(PHASE_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .phase_step   (cfg.phase_step),
    .push         (push),
    .phase_restart(phase_restart),
    .q_full       (full),
    .q_push       (q_push),
    .q_data       (q_wdata)
  );

  mwpo_queue #(
    .W(PHASE_BITS + 1)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .wr   (q_push),
    .wdata(q_wdata),
    .rd   (q_pop),
    .rdata(q_rdata),
    .full (full),
    .empty(q_empty)
  );

  mwpo_back #(
    .PHASE_BITS      (PHASE_BITS),
    .MAX_HARMONICS   (MAX_HARMONICS),
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .q_empty(q_empty),
    .q_data (q_rdata),
    .q_pop  (q_pop),
    .empty  (empty),
    .pop    (pop),
    .sample (sample),
    .clipped(clipped)
  );

endmodule

[tb/sv/multi_waveform_phase_oscillator_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_waveform_phase_oscillator_tb
// Drives sample requests through the oscillator over many register settings:
// a directed pass over every waveform and corner, one long output stall, then
// randomised phases with random idling on both sides. A scoreboard keeps
// its own phase accumulator and sine table and checks every sample in order.
// ----------------------------------------------------------------------------
module multi_waveform_phase_oscillator_tb;
  import mwpo_pkg::*;

  localparam int PB    = DEF_PHASE_BITS;
  localparam int DEPTH = DEF_SINE_TABLE_DEPTH;
  localparam int MAXH  = DEF_MAX_HARMONICS;
  localparam longint unsigned PMASK = (64'd1 << PB) - 1;
  localparam longint LIMIT_CYCLES = 30000000;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       clipped;
  } tone_t;

  // Scoreboard: register mirror, phase state and the queue of due samples
  class sample_ledger;
    longint unsigned sine_quarter [DEPTH+1];
    cfg_t            regs;
    logic [PB-1:0]   phase;
    logic            wrapped;
    tone_t           due [$];
    int              faults;

    function new();
      longint unsigned u, u2, t, x, s;
      for (int i = 0; i <= DEPTH; i++) begin
        u  = (longint'(i) << 30) / DEPTH;
        u2 = (u * u) >> 30;
        t  = TAYLOR_Q30[6];
        for (int k = 5; k >= 0; k--) begin
          x = (u2 * t) >> 30;
          t = (x > TAYLOR_Q30[k]) ? 64'd0 : TAYLOR_Q30[k] - x;
        end
        s = (u * t) >> 30;
        s = (s + (64'd1 << 13)) >> 14;
        if (s > 65536) s = 65536;
        sine_quarter[i] = s;
      end
      regs    = '0;
      phase   = '0;
      wrapped = 1'b0;
      faults  = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_WAVEFORM:       regs.waveform       = val[3:0];
        REG_PHASE_STEP:     regs.phase_step     = val[23:0];
        REG_LEVEL:          regs.level          = val[15:0];
        REG_HARMONIC_COUNT: regs.harmonic_count = val[7:0];
        REG_IMPULSE_GAIN:   regs.impulse_gain   = val[15:0];
        default: ;
      endcase
    endfunction

    function longint sine_of(longint unsigned p);
      longint unsigned quad, frac, idx, v;
      quad = (p >> (PB - 2)) & 3;
      frac = p & ((64'd1 << (PB - 2)) - 1);
      idx  = (frac * DEPTH) >> (PB - 2);
      if (idx > DEPTH) idx = DEPTH;
      if (quad[0]) idx = DEPTH - idx;
      v = sine_quarter[idx];
      return quad[1] ? -longint'(v) : longint'(v);
    endfunction

    function longint scale_signed(longint a, longint unsigned m);
      longint unsigned mag;
      longint r;
      mag = (a < 0) ? longint'(-a) : a;
      r   = longint'((mag * m) >> (PB - 16));
      return (a < 0) ? -r : r;
    endfunction

    function longint harmonic_sum(longint unsigned p);
      longint unsigned nh, weight, divisor, mag;
      longint acc, s;
      acc = 0;
      nh  = (regs.harmonic_count > MAXH) ? MAXH : regs.harmonic_count;
      for (longint unsigned h = 1; h <= nh; h++) begin
        weight  = regs.level;
        divisor = 1;
        if (regs.waveform == WAVE_BL_IMP) begin
          weight = regs.impulse_gain;
        end else if (regs.waveform == WAVE_BL_SAW) begin
          divisor = h;
        end else begin
          if (h[0] == 1'b0) continue;
          divisor = (regs.waveform == WAVE_BL_SQR) ? h : h * h;
        end
        s   = sine_of((p * h) & PMASK);
        mag = (longint'(s < 0 ? -s : s) * weight) / divisor;
        acc += (s < 0) ? -longint'(mag) : longint'(mag);
      end
      return acc;
    endfunction

    // Work out the sample for one request and advance the phase
    function tone_t predict_sample(logic restart);
      longint unsigned p, full_cycle, mag, nxt;
      longint acc, s;
      tone_t r;
      if (restart) begin
        phase   = '0;
        wrapped = 1'b0;
      end
      p          = phase;
      full_cycle = 64'd1 << PB;
      acc        = 0;
      r.clipped  = 1'b0;
      case (regs.waveform)
        WAVE_SINE:     acc = sine_of(p) * longint'(regs.level);
        WAVE_IMPULSE:  acc = wrapped ? longint'(regs.level) << 16 : 0;
        WAVE_SQUARE:   acc = (p < full_cycle / 2) ? -(longint'(regs.level) << 16)
                                                  : longint'(regs.level) << 16;
        WAVE_SAW:      acc = scale_signed(longint'(2 * p) - longint'(full_cycle),
                                          regs.level);
        WAVE_TRIANGLE: begin
          if (p < full_cycle / 2) s = longint'(4 * p) - longint'(full_cycle);
          else s = longint'(3 * full_cycle) - longint'(4 * p);
          acc = scale_signed(s, regs.level);
        end
        WAVE_BL_IMP, WAVE_BL_SQR, WAVE_BL_SAW, WAVE_BL_TRI: acc = harmonic_sum(p);
        default: acc = 0;
      endcase
      mag = (acc < 0) ? longint'(-acc) : acc;
      s   = longint'(mag >> 16);
      if (acc < 0) s = -s;
      if (s > 131071) begin
        s = 131071;
        r.clipped = 1'b1;
      end else if (s < -131072) begin
        s = -131072;
        r.clipped = 1'b1;
      end
      r.sample = s[SAMPLE_W-1:0];
      nxt      = p + regs.phase_step;
      wrapped  = nxt > PMASK;
      phase    = nxt[PB-1:0];
      return r;
    endfunction

    function void note_request(logic restart);
      due.insert(due.size(), predict_sample(restart));
    endfunction

    function void check_result(logic signed [SAMPLE_W-1:0] smp, logic clp);
      tone_t e;
      if (due.size() == 0) begin
        $display("%0t: unexpected sample %0d clipped %0b", $time, smp, clp);
        faults++;
        return;
      end
      e = due.pop_front();
      if (smp !== e.sample) begin
        $display("%0t: sample expected %0d actual %0d", $time, e.sample, smp);
        faults++;
      end
      if (clp !== e.clipped) begin
        $display("%0t: clipped expected %0b actual %0b", $time, e.clipped, clp);
        faults++;
      end
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       cfg_write;
  logic [CFG_INDEX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_data;
  logic                       push;
  logic                       full;
  logic                       phase_restart;
  logic                       empty;
  logic                       pop;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       clipped;

  sample_ledger ledger;
  int           sent;
  bit           send_gapless;
  bit           drain_hold;
  longint       cycles;

  multi_waveform_phase_oscillator dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .push(push), .full(full), .phase_restart(phase_restart),
    .empty(empty), .pop(pop), .sample(sample), .clipped(clipped)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    ledger.set_reg(idx, val);
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // Send n requests; restart_pct is the chance of a phase restart per request
  task automatic send_requests(int n, int restart_pct);
    int gap;
    for (int i = 0; i < n; i++) begin
      gap = send_gapless ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        push = 1'b0;
        repeat (gap) @(negedge clk);
      end
      push          = 1'b1;
      phase_restart = ($urandom_range(0, 99) < restart_pct);
      do @(posedge clk); while (full);
      ledger.note_request(phase_restart);
      sent++;
      @(negedge clk);
    end
    push = 1'b0;
  endtask

  // Drain all samples, let the engine settle, load a full setting, then send the requests
  task automatic run_phase(logic [3:0] wave, logic [23:0] step, logic [15:0] lvl,
                           logic [7:0] nh, logic [15:0] gain, int n, int restart_pct);
    while (ledger.pending() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    write_reg(REG_WAVEFORM, CFG_DATA_W'(wave));
    write_reg(REG_PHASE_STEP, CFG_DATA_W'(step));
    write_reg(REG_LEVEL, CFG_DATA_W'(lvl));
    write_reg(REG_HARMONIC_COUNT, CFG_DATA_W'(nh));
    write_reg(REG_IMPULSE_GAIN, CFG_DATA_W'(gain));
    send_requests(n, restart_pct);
  endtask

  // Result side: random pop idling, with a long hold when asked
  initial begin
    int gap;
    int left;
    bit steady;
    pop    = 1'b0;
    left   = 0;
    steady = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (left == 0) begin
        steady = ($urandom_range(0, 3) == 0);
        left   = $urandom_range(5, 40);
      end
      left--;
      gap = steady ? 0 : $urandom_range(0, 16);
      if (drain_hold) begin
        gap        = 400;
        drain_hold = 1'b0;
      end
      if (gap > 0) begin
        pop = 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop = 1'b1;
      do @(posedge clk); while (empty);
      ledger.check_result(sample, clipped);
      @(negedge clk);
    end
  end

  // Stimulus
  initial begin
    logic [3:0]  wave;
    logic [23:0] step;
    logic [15:0] lvl;
    logic [7:0]  nh;
    logic [15:0] gain;
    int          n;
    ledger        = new();
    sent          = 0;
    send_gapless  = 1'b0;
    drain_hold    = 1'b0;
    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    push          = 1'b0;
    phase_restart = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: each waveform at full level or gain, restart, unused code, clamp, zero step
    run_phase(WAVE_SILENT, 24'hFFFFFF, 16'hFFFF, 8'd0, 16'h0000, 1, 0);
    run_phase(WAVE_SINE, 24'h155555, 16'hFFFF, 8'd0, 16'h0000, 3, 0);
    run_phase(WAVE_IMPULSE, 24'h800000, 16'hFFFF, 8'd0, 16'h0000, 3, 0);
    run_phase(WAVE_SQUARE, 24'h400000, 16'hFFFF, 8'd0, 16'h0000, 2, 100);
    run_phase(WAVE_SAW, 24'h7FFFFF, 16'hFFFF, 8'd0, 16'h0000, 2, 0);
    run_phase(WAVE_TRIANGLE, 24'h300000, 16'hFFFF, 8'd0, 16'h0000, 2, 0);
    run_phase(WAVE_BL_IMP, 24'h0A0000, 16'h0000, 8'd6, 16'hFFFF, 2, 0);
    run_phase(WAVE_BL_SQR, 24'h0A0000, 16'hFFFF, 8'd7, 16'h0000, 2, 0);
    run_phase(WAVE_BL_SAW, 24'h050000, 16'hFFFF, 8'd200, 16'h0000, 1, 0);
    run_phase(WAVE_BL_TRI, 24'h0A0000, 16'hFFFF, 8'd0, 16'h0000, 1, 0);
    run_phase(4'd12, 24'h123456, 16'hFFFF, 8'd5, 16'hFFFF, 1, 0);
    run_phase(WAVE_IMPULSE, 24'h000000, 16'hFFFF, 8'd0, 16'h0000, 2, 0);

    // Fill the block while the output side holds off
    drain_hold   = 1'b1;
    send_gapless = 1'b1;
    run_phase(WAVE_SQUARE, 24'h0F0F0F, 16'h8001, 8'd3, 16'h1234, 40, 10);
    send_gapless = 1'b0;

    // Random phases
    while (sent < 1000) begin
      wave = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                         : 4'($urandom_range(1, 9));
      case ($urandom_range(0, 5))
        0:       step = 24'h000000;
        1:       step = 24'hFFFFFF;
        2:       step = 24'($urandom_range(0, 24'h00FFFF));
        default: step = 24'($urandom);
      endcase
      case ($urandom_range(0, 4))
        0:       lvl = 16'h0000;
        1:       lvl = 16'hFFFF;
        default: lvl = 16'($urandom);
      endcase
      gain = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
      n    = $urandom_range(10, 40);
      if ($urandom_range(0, 11) == 0) begin
        nh = ($urandom_range(0, 1) == 0) ? 8'd128 : 8'($urandom_range(129, 255));
        n  = $urandom_range(1, 3);
      end else begin
        nh = 8'($urandom_range(0, 10));
      end
      send_gapless = ($urandom_range(0, 3) == 0);
      run_phase(wave, step, lvl, nh, gain, n, $urandom_range(0, 15));
    end
    send_gapless = 1'b0;

    // Drain and settle
    while (ledger.pending() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (ledger.faults == 0 && ledger.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
